### design/hbw_pkg.sv
// shared types, constants and widths for the band threshold homography warp
package hbw_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int BAND_LOW     = 100;
    localparam int BAND_HIGH    = 170;

    localparam int NUM_REGS = 8;
    localparam int COEF_W   = 32;
    localparam int SUM_W    = 44;   // signed numerator / denominator sums
    localparam int DIV_W    = 46;   // unsigned 2n+d and 2d
    localparam int Q_BITS   = 16;   // quotient bits resolved by the divider
    localparam int REM_W    = DIV_W + Q_BITS;

    localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(65536);

    // register indexes
    localparam logic [2:0] REG_XX = 3'd0;
    localparam logic [2:0] REG_XY = 3'd1;
    localparam logic [2:0] REG_XO = 3'd2;
    localparam logic [2:0] REG_YX = 3'd3;
    localparam logic [2:0] REG_YY = 3'd4;
    localparam logic [2:0] REG_YO = 3'd5;
    localparam logic [2:0] REG_WX = 3'd6;
    localparam logic [2:0] REG_WY = 3'd7;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_set_t;

    typedef struct packed {
        logic [7:0] grey_value;
        logic [9:0] column;
        logic [8:0] row;
    } pixel_t;

    typedef struct packed {
        logic               in_band;
        logic signed [15:0] proj_x;
        logic signed [15:0] proj_y;
        logic               degenerate;
    } result_t;

    // per-item status leaving the front end
    typedef struct packed {
        logic valid;
        logic band;
        logic degen;
    } side_t;

    // divider operand for one axis
    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic             neg;
        logic             ovf;
    } div_op_t;

endpackage

### design/hbw_front.sv
// band test, homography products and sums, divider operand preparation
module hbw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hbw_pkg::pixel_t    pixel,
    input  hbw_pkg::coef_set_t coefs,
    output hbw_pkg::side_t     side,
    output hbw_pkg::div_op_t   op_x,
    output hbw_pkg::div_op_t   op_y,
    output logic [hbw_pkg::DIV_W-1:0] den2
);

    localparam int SW = hbw_pkg::SUM_W;
    localparam int DW = hbw_pkg::DIV_W;

    // stage 1 registers
    logic       v1_reg, band1_reg;
    logic [9:0] col1_reg;
    logic [8:0] row1_reg;

    // stage 2 registers
    logic v2_reg, band2_reg;
    logic signed [SW-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg, pwx_reg, pwy_reg;

    // stage 3 registers
    logic v3_reg, band3_reg;
    logic signed [SW-1:0] nx_reg, ny_reg, den_reg;

    // stage 4 registers
    hbw_pkg::side_t   side_reg;
    hbw_pkg::div_op_t opx_reg, opy_reg;
    logic [DW-1:0]    d2_reg;

    logic band_next;
    logic signed [SW-1:0] nx_next, ny_next, den_next;
    logic [SW-1:0] mx, my, md;
    logic [DW-1:0] nx2, ny2, d2_next;
    logic [hbw_pkg::REM_W-1:0] dlim;

    // band test on the incoming pixel
    assign band_next = (pixel.grey_value > 8'(hbw_pkg::BAND_LOW))
                    && (pixel.grey_value < 8'(hbw_pkg::BAND_HIGH))
                    && (pixel.column < 10'(hbw_pkg::IMAGE_WIDTH))
                    && ({1'b0, pixel.row} < 10'(hbw_pkg::IMAGE_HEIGHT));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            side_reg <= '0;
        end
        else
        begin
            v1_reg         <= start;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            side_reg.valid <= v3_reg;
            side_reg.band  <= band3_reg;
            side_reg.degen <= (den_reg == '0);
        end
    end

    // sums of the products plus offset terms
    assign nx_next  = pxx_reg + pxy_reg + SW'($signed(coefs[hbw_pkg::REG_XO]));
    assign ny_next  = pyx_reg + pyy_reg + SW'($signed(coefs[hbw_pkg::REG_YO]));
    assign den_next = pwx_reg + pwy_reg + SW'($signed(hbw_pkg::Q_ONE));

    // magnitudes and rounding operands: 2n+d over 2d
    assign mx = nx_reg[SW-1]  ? SW'(-nx_reg)  : SW'(nx_reg);
    assign my = ny_reg[SW-1]  ? SW'(-ny_reg)  : SW'(ny_reg);
    assign md = den_reg[SW-1] ? SW'(-den_reg) : SW'(den_reg);
    assign nx2     = DW'({mx, 1'b0}) + DW'(md);
    assign ny2     = DW'({my, 1'b0}) + DW'(md);
    assign d2_next = {1'b0, md, 1'b0};
    assign dlim    = {d2_next, {hbw_pkg::Q_BITS{1'b0}}};

    // payload pipeline
    always_ff @(posedge clk)
    begin
        band1_reg <= band_next;
        col1_reg  <= pixel.column;
        row1_reg  <= pixel.row;

        band2_reg <= band1_reg;
        pxx_reg <= SW'($signed(coefs[hbw_pkg::REG_XX]) * $signed({1'b0, col1_reg}));
        pxy_reg <= SW'($signed(coefs[hbw_pkg::REG_XY]) * $signed({1'b0, row1_reg}));
        pyx_reg <= SW'($signed(coefs[hbw_pkg::REG_YX]) * $signed({1'b0, col1_reg}));
        pyy_reg <= SW'($signed(coefs[hbw_pkg::REG_YY]) * $signed({1'b0, row1_reg}));
        pwx_reg <= SW'($signed(coefs[hbw_pkg::REG_WX]) * $signed({1'b0, col1_reg}));
        pwy_reg <= SW'($signed(coefs[hbw_pkg::REG_WY]) * $signed({1'b0, row1_reg}));

        band3_reg <= band2_reg;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        den_reg   <= den_next;

        opx_reg.num <= nx2;
        opx_reg.neg <= nx_reg[SW-1] ^ den_reg[SW-1];
        opx_reg.ovf <= {{hbw_pkg::Q_BITS{1'b0}}, nx2} >= dlim;
        opy_reg.num <= ny2;
        opy_reg.neg <= ny_reg[SW-1] ^ den_reg[SW-1];
        opy_reg.ovf <= {{hbw_pkg::Q_BITS{1'b0}}, ny2} >= dlim;
        d2_reg      <= d2_next;
    end

    assign side = side_reg;
    assign op_x = opx_reg;
    assign op_y = opy_reg;
    assign den2 = d2_reg;

endmodule

### design/hbw_divider.sv
// pipelined restoring divider, one quotient bit per stage
module hbw_divider (
    input  logic                      clk,
    input  hbw_pkg::div_op_t          op,
    input  logic [hbw_pkg::DIV_W-1:0] den2,
    output logic [hbw_pkg::Q_BITS-1:0] quot,
    output logic                      neg,
    output logic                      ovf
);

    localparam int QB = hbw_pkg::Q_BITS;
    localparam int RW = hbw_pkg::REM_W;
    localparam int DW = hbw_pkg::DIV_W;

    logic [RW-1:0] rem_reg  [1:QB];
    logic [DW-1:0] den_reg  [1:QB];
    logic [QB-1:0] quot_reg [1:QB];
    logic          neg_reg  [1:QB];
    logic          ovf_reg  [1:QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quot_in;
        logic          neg_in;
        logic          ovf_in;
        logic [RW-1:0] dsh;
        logic          take;

        // stage 0 takes the operands as they are
        if (k == 0)
        begin : g_in
            assign rem_in  = {{QB{1'b0}}, op.num};
            assign den_in  = den2;
            assign quot_in = '0;
            assign neg_in  = op.neg;
            assign ovf_in  = op.ovf;
        end
        else
        begin : g_in
            assign rem_in  = rem_reg[k];
            assign den_in  = den_reg[k];
            assign quot_in = quot_reg[k];
            assign neg_in  = neg_reg[k];
            assign ovf_in  = ovf_reg[k];
        end

        // trial subtract of the shifted divisor
        assign dsh  = {{QB{1'b0}}, den_in} << (QB - 1 - k);
        assign take = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= take ? rem_in - dsh : rem_in;
            den_reg[k+1]  <= den_in;
            quot_reg[k+1] <= {quot_in[QB-2:0], take};
            neg_reg[k+1]  <= neg_in;
            ovf_reg[k+1]  <= ovf_in;
        end
    end

    assign quot = quot_reg[QB];
    assign neg  = neg_reg[QB];
    assign ovf  = ovf_reg[QB];

endmodule

### design/band_threshold_homography_warp_unit.sv
// top level: registers, front end, two dividers and output saturation
//
// Takes one grey pixel with its column and row per transfer and returns one
// result per pixel: an in-band flag, the pixel mapped through a normalized
// planar homography and rounded to the nearest integer, and a flag for a
// zero projective denominator; both read zero for an out-of-band pixel.
// Input: a transfer happens on a clock edge with start high and busy low.
// busy is always low, so a pixel can enter on every cycle.
// Output: result is shown for one cycle with done high, after the pixel has passed
// 4 front-end stages, 16 divider stages and 1 output stage, in that order; the
// accepting edge loads the first front-end stage.
// Throughput is one pixel per clock; the divider resolves one quotient bit
// per stage for both axes in parallel.
// Configuration: cfg_we writes cfg_data into the coefficient at cfg_index on
// the same edge; write only with no pixel in flight.
// Reset clears the pipeline valid bits and loads the identity homography.
// The receiver has no way to stall; every result must be taken as it comes.
module band_threshold_homography_warp_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hbw_pkg::pixel_t     pixel,
    output logic                done,
    output hbw_pkg::result_t    result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int QB = hbw_pkg::Q_BITS;

    // identity homography, ordered from the last register down to the first
    localparam hbw_pkg::coef_set_t COEF_RESET = {{3{32'd0}}, hbw_pkg::Q_ONE,
                                                 {3{32'd0}}, hbw_pkg::Q_ONE};

    hbw_pkg::coef_set_t coef_reg;
    hbw_pkg::side_t     side;
    hbw_pkg::div_op_t   op_x, op_y;
    logic [hbw_pkg::DIV_W-1:0] den2;
    logic [QB-1:0] qx, qy;
    logic          negx, negy, ovfx, ovfy;
    hbw_pkg::side_t side_reg [1:QB];
    logic           done_reg;
    hbw_pkg::result_t result_reg, result_next;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    hbw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pixel (pixel),
        .coefs (coef_reg),
        .side  (side),
        .op_x  (op_x),
        .op_y  (op_y),
        .den2  (den2)
    );

    hbw_divider u_div_x (
        .clk  (clk),
        .op   (op_x),
        .den2 (den2),
        .quot (qx),
        .neg  (negx),
        .ovf  (ovfx)
    );

    hbw_divider u_div_y (
        .clk  (clk),
        .op   (op_y),
        .den2 (den2),
        .quot (qy),
        .neg  (negy),
        .ovf  (ovfy)
    );

    // status travels alongside the divider stages
    for (genvar k = 0; k < QB; k++)
    begin : g_side
        hbw_pkg::side_t side_in;

        if (k == 0)
        begin : g_in
            assign side_in = side;
        end
        else
        begin : g_in
            assign side_in = side_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k+1] <= '0;
            end
            else
            begin
                side_reg[k+1] <= side_in;
            end
        end
    end

    // apply sign and saturate one axis
    function automatic logic signed [15:0] sat_q(input logic [QB-1:0] q,
                                                 input logic neg,
                                                 input logic ovf);
        logic [QB:0] qe;
        qe = {1'b0, q};
        if (neg)
        begin
            if (ovf || qe > 17'd32768)
                sat_q = 16'sh8000;
            else
                sat_q = 16'(-qe);
        end
        else
        begin
            if (ovf || qe > 17'd32767)
                sat_q = 16'sh7fff;
            else
                sat_q = 16'(qe);
        end
    endfunction

    // out-of-band pixels give all-zero fields
    always_comb
    begin
        result_next = '0;
        if (side_reg[QB].band)
        begin
            result_next.in_band    = 1'b1;
            result_next.proj_x     = sat_q(qx, negx, ovfx);
            result_next.proj_y     = sat_q(qy, negy, ovfy);
            result_next.degenerate = side_reg[QB].degen;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_reg[QB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
